### rtl/gtg_pkg.sv
// Package for the go-to-goal heading controller.
// Holds formats, register indexes, thresholds and the CORDIC arctangent table.
// No dependencies.
package gtg_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 17;
  localparam int ITER_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  localparam logic [1:0] REG_GOAL_X      = 2'd0;
  localparam logic [1:0] REG_GOAL_Y      = 2'd1;
  localparam logic [1:0] REG_GAIN        = 2'd2;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

  localparam logic [15:0] GOAL_MAX  = 16'd49152;
  localparam logic [15:0] REG_RESET = 16'd4096;

  // distance > 0.1 : 100 * sumsq > 2^(2*FRAC_BITS)
  localparam logic [33:0] NEAR_THR = 34'((64'd1 << (2 * FRAC_BITS)) / 64'd100);
  // abs error > 0.2 : 10 * err > 2 * 2^FRAC_BITS
  localparam logic [18:0] TURN_THR = 19'((64'd2 << FRAC_BITS) / 64'd10);

  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam int ANG_SHIFT = 30 - FRAC_BITS;
  localparam logic signed [35:0] ANG_RND = 36'sd1 <<< (ANG_SHIFT - 1);

  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [35:0] z;
    logic        [33:0] v;
    logic        [34:0] r;
    logic               near;
    logic signed [14:0] hd;
  } iter_t;

  function automatic logic signed [35:0] atan_q30(input int idx);
    logic signed [35:0] a;
    unique case (idx)
      0:  a = 36'sd843314857;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043837;
      3:  a = 36'sd133525159;
      4:  a = 36'sd67021687;
      5:  a = 36'sd33543516;
      6:  a = 36'sd16775851;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194283;
      9:  a = 36'sd2097149;
      10: a = 36'sd1048576;
      11: a = 36'sd524288;
      12: a = 36'sd262144;
      13: a = 36'sd131072;
      14: a = 36'sd65536;
      15: a = 36'sd32768;
      16: a = 36'sd16384;
      17: a = 36'sd8192;
      18: a = 36'sd4096;
      19: a = 36'sd2048;
      20: a = 36'sd1024;
      21: a = 36'sd512;
      22: a = 36'sd256;
      23: a = 36'sd128;
      default: a = 36'sd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/go_to_goal_heading_controller_top.sv
// Top level of the go-to-goal heading controller: pipelined CORDIC bearing,
// pipelined integer square root, threshold selection and speed saturation.
// Depends on gtg_pkg.
//
// channel  ports                                         handshake
// input    in_pos_x, in_pos_y, in_heading                start & !busy
// result   out_linear_speed, out_turn_rate               out_valid, one cycle
// config   cfg_index, cfg_wdata                          cfg_we
//
// One item per cycle; the iteration pipeline depth (ITER_STAGES) is set by the 17-step
// square root pipeline beside CORDIC.
// busy stays low: every stage advances each cycle and the receiver takes
// every result. Synchronous reset clears valid bits and loads registers to 1.0.
module go_to_goal_heading_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  output logic        out_valid,
  output logic [15:0] out_linear_speed,
  output logic [14:0] out_turn_rate,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int N = gtg_pkg::ITER_STAGES;

  logic [15:0] goal_x_r, goal_y_r, gain_r, speed_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r      <= gtg_pkg::REG_RESET;
      goal_y_r      <= gtg_pkg::REG_RESET;
      gain_r        <= gtg_pkg::REG_RESET;
      speed_limit_r <= gtg_pkg::REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtg_pkg::REG_GOAL_X: begin
          if (cfg_wdata <= gtg_pkg::GOAL_MAX) goal_x_r <= cfg_wdata;
        end
        gtg_pkg::REG_GOAL_Y: begin
          if (cfg_wdata <= gtg_pkg::GOAL_MAX) goal_y_r <= cfg_wdata;
        end
        gtg_pkg::REG_GAIN:        gain_r        <= cfg_wdata;
        gtg_pkg::REG_SPEED_LIMIT: speed_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid chain: s1, s2, s3 (iteration input), iterations, p1, p2
  logic           v1_r, v2_r;
  logic [N:0]     vit_r;
  logic           vp1_r, vp2_r;

  logic signed [16:0] dx1_r, dy1_r;
  logic signed [14:0] hd1_r, hd2_r;
  logic        [32:0] sqx2_r, sqy2_r;
  logic signed [39:0] cx2_r, cy2_r;
  logic signed [35:0] cz2_r;

  gtg_pkg::iter_t it_r [0:N];
  gtg_pkg::iter_t it_nxt [0:N-1];

  logic [33:0] sumsq_nxt;
  logic signed [39:0] cx_nxt, cy_nxt;
  logic signed [35:0] cz_nxt;

  assign sumsq_nxt = {1'b0, sqx2_r} + {1'b0, sqy2_r};

  always_comb begin
    cx_nxt = 40'(dx1_r) <<< 16;
    cy_nxt = 40'(dy1_r) <<< 16;
    cz_nxt = '0;
    if (dx1_r < 0) begin
      cx_nxt = -cx_nxt;
      cy_nxt = -cy_nxt;
      cz_nxt = (dy1_r >= 0) ? gtg_pkg::PI_Q30 : -gtg_pkg::PI_Q30;
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin : step
      logic signed [39:0] xs, ys;
      logic        [34:0] b, rb;
      xs = it_r[k].x >>> k;
      ys = it_r[k].y >>> k;
      it_nxt[k] = it_r[k];
      if (k < gtg_pkg::CORDIC_STEPS) begin
        if (!it_r[k].y[39]) begin
          it_nxt[k].x = it_r[k].x + ys;
          it_nxt[k].y = it_r[k].y - xs;
          it_nxt[k].z = it_r[k].z + gtg_pkg::atan_q30(k);
        end else begin
          it_nxt[k].x = it_r[k].x - ys;
          it_nxt[k].y = it_r[k].y + xs;
          it_nxt[k].z = it_r[k].z - gtg_pkg::atan_q30(k);
        end
      end
      b  = 35'd1 << (2 * (gtg_pkg::SQRT_STEPS - 1) - 2 * k);
      rb = it_r[k].r + b;
      if (k < gtg_pkg::SQRT_STEPS) begin
        if ({1'b0, it_r[k].v} >= rb) begin
          it_nxt[k].v = 34'({1'b0, it_r[k].v} - rb);
          it_nxt[k].r = (it_r[k].r >> 1) + b;
        end else begin
          it_nxt[k].r = it_r[k].r >> 1;
        end
      end
    end
  end

  // post stage 1
  logic signed [35:0] zr;
  logic signed [17:0] ang;
  logic signed [18:0] err, aerr;
  logic [16:0] root_len;
  assign zr   = it_r[N].z + gtg_pkg::ANG_RND;
  assign ang  = 18'(zr >>> gtg_pkg::ANG_SHIFT);
  assign err  = 19'(ang) - 19'(it_r[N].hd);
  assign aerr = err[18] ? -err : err;
  assign root_len = it_r[N].r[16:0];

  logic        near_p1_r, turn_p1_r;
  logic [14:0] aerr_p1_r;
  logic [32:0] prod_p1_r;

  logic [20:0] lin_full;
  logic [15:0] lin_sat;
  assign lin_full = prod_p1_r[32:gtg_pkg::FRAC_BITS];
  assign lin_sat  = (lin_full > 21'(speed_limit_r)) ? speed_limit_r : lin_full[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vit_r <= '0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
    end else begin
      v1_r  <= start && !busy;
      v2_r  <= v1_r;
      vit_r <= {vit_r[N-1:0], v2_r};
      vp1_r <= vit_r[N];
      vp2_r <= vp1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r <= 17'({1'b0, goal_x_r}) - 17'({1'b0, in_pos_x});
    dy1_r <= 17'({1'b0, goal_y_r}) - 17'({1'b0, in_pos_y});
    hd1_r <= in_heading;

    sqx2_r <= 33'(dx1_r) * 33'(dx1_r);
    sqy2_r <= 33'(dy1_r) * 33'(dy1_r);
    cx2_r  <= cx_nxt;
    cy2_r  <= cy_nxt;
    cz2_r  <= cz_nxt;
    hd2_r  <= hd1_r;

    it_r[0].x    <= cx2_r;
    it_r[0].y    <= cy2_r;
    it_r[0].z    <= cz2_r;
    it_r[0].v    <= sumsq_nxt;
    it_r[0].r    <= '0;
    it_r[0].near <= sumsq_nxt <= gtg_pkg::NEAR_THR;
    it_r[0].hd   <= hd2_r;
    for (int k = 0; k < N; k++) it_r[k+1] <= it_nxt[k];

    near_p1_r <= it_r[N].near;
    turn_p1_r <= aerr > gtg_pkg::TURN_THR;
    aerr_p1_r <= aerr[14:0];
    prod_p1_r <= 33'(gain_r) * 33'(root_len);

    if (near_p1_r) begin
      out_linear_speed <= '0;
      out_turn_rate    <= '0;
    end else if (turn_p1_r) begin
      out_linear_speed <= '0;
      out_turn_rate    <= aerr_p1_r;
    end else begin
      out_linear_speed <= lin_sat;
      out_turn_rate    <= '0;
    end
  end

  assign out_valid = vp2_r;

endmodule

### sim/tb_go_to_goal_heading_controller_top.sv
// Self-checking testbench for go_to_goal_heading_controller_top.
// Drives pose items through phases of goal, gain and speed-limit settings and
// checks each result against a typed expected row or an in-bench CORDIC/square-root predictor; uses gtg_pkg.
`timescale 1ns / 100ps

module tb_go_to_goal_heading_controller_top;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint PI_RAD_Q30 = 64'sd3373259426;

  typedef struct {
    logic [15:0] lin;
    logic [14:0] turn;
  } cmd_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] hd;
    bit          typed;
    logic [15:0] lin;
    logic [14:0] turn;
  } pose_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic signed [14:0] in_heading = '0;
  logic out_valid;
  logic [15:0] out_linear_speed;
  logic [14:0] out_turn_rate;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  bit          row_typed = 1'b0;
  logic [15:0] row_lin = '0;
  logic [14:0] row_turn = '0;

  logic [15:0] goal_x_m, goal_y_m, gain_m, limit_m;
  cmd_t pending_cmds[$];
  int errors = 0;
  int cycles = 0;

  go_to_goal_heading_controller_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_heading(in_heading),
    .out_valid(out_valid), .out_linear_speed(out_linear_speed),
    .out_turn_rate(out_turn_rate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic longint goal_bearing(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
    end
    for (int i = 0; i < gtg_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(gtg_pkg::atan_q30(i));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(gtg_pkg::atan_q30(i));
      end
    end
    return (z + (longint'(1) << (29 - gtg_pkg::FRAC_BITS))) >>> (30 - gtg_pkg::FRAC_BITS);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic cmd_t steer_cmd(input logic [15:0] px, input logic [15:0] py,
                                     input logic signed [14:0] hd);
    longint dx, dy, err;
    longint unsigned sumsq, one, lin;
    cmd_t c;
    c.lin = '0;
    c.turn = '0;
    one = 64'd1 << gtg_pkg::FRAC_BITS;
    dx = longint'(goal_x_m) - longint'(px);
    dy = longint'(goal_y_m) - longint'(py);
    sumsq = dx * dx + dy * dy;
    if (100 * sumsq > one * one) begin
      err = goal_bearing(dx, dy) - longint'(hd);
      if (err < 0) err = -err;
      if (10 * err > 2 * one) begin
        c.turn = err[14:0];
      end else begin
        lin = (longint'(gain_m) * root_floor(sumsq)) >> gtg_pkg::FRAC_BITS;
        if (lin > limit_m) lin = limit_m;
        c.lin = lin[15:0];
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_t exp_c;
    cmd_t got_c;
    if (!rst_n) begin
      goal_x_m <= gtg_pkg::REG_RESET;
      goal_y_m <= gtg_pkg::REG_RESET;
      gain_m <= gtg_pkg::REG_RESET;
      limit_m <= gtg_pkg::REG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gtg_pkg::REG_GOAL_X:      if (cfg_wdata <= gtg_pkg::GOAL_MAX) goal_x_m <= cfg_wdata;
          gtg_pkg::REG_GOAL_Y:      if (cfg_wdata <= gtg_pkg::GOAL_MAX) goal_y_m <= cfg_wdata;
          gtg_pkg::REG_GAIN:        gain_m <= cfg_wdata;
          gtg_pkg::REG_SPEED_LIMIT: limit_m <= cfg_wdata;
        endcase
      end
      if (start && !busy) begin
        if (row_typed) begin
          exp_c.lin = row_lin;
          exp_c.turn = row_turn;
        end else begin
          exp_c = steer_cmd(in_pos_x, in_pos_y, in_heading);
        end
        pending_cmds.push_back(exp_c);
      end
      if (out_valid) begin
        got_c.lin = out_linear_speed;
        got_c.turn = out_turn_rate;
        if (pending_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected result lin=%0d turn=%0d", $time, got_c.lin, got_c.turn);
        end else begin
          exp_c = pending_cmds.pop_front();
          if (got_c.lin !== exp_c.lin) begin
            errors++;
            $display("%0t: linear_speed expected %0d got %0d", $time, exp_c.lin, got_c.lin);
          end
          if (got_c.turn !== exp_c.turn) begin
            errors++;
            $display("%0t: turn_rate expected %0d got %0d", $time, exp_c.turn, got_c.turn);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_to_goal_heading_controller_top: mismatch");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_pose(input pose_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start <= 1'b1;
    in_pos_x <= r.x;
    in_pos_y <= r.y;
    in_heading <= r.hd;
    row_typed <= r.typed;
    row_lin <= r.lin;
    row_turn <= r.turn;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle;
    start <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pose_row_t random_pose();
    pose_row_t r;
    logic signed [14:0] aim;
    int mode;
    mode = $urandom_range(0, 9);
    r.typed = 1'b0;
    r.lin = '0;
    r.turn = '0;
    r.x = $urandom_range(0, 65535);
    r.y = $urandom_range(0, 65535);
    if (mode < 3) r.x = $urandom_range(0, 16384);
    if (mode < 3) r.y = $urandom_range(0, 16384);
    if (mode == 3) begin
      r.x = goal_x_m + 16'($urandom_range(0, 1000)) - 16'd500;
      r.y = goal_y_m + 16'($urandom_range(0, 1000)) - 16'd500;
    end
    if (mode < 2) begin
      r.hd = $urandom_range(0, 32767);
    end else begin
      aim = 15'(goal_bearing(longint'(goal_x_m) - longint'(r.x),
                             longint'(goal_y_m) - longint'(r.y)));
      r.hd = aim + 15'($urandom_range(0, 2000)) - 15'sd1000;
    end
    return r;
  endfunction

  pose_row_t directed_rows[] = '{
    '{16'd4096,  16'd4096,  15'sd0,      1'b1, 16'd0,    15'd0},
    '{16'd0,     16'd4096,  15'sd0,      1'b1, 16'd4096, 15'd0},
    '{16'd4096,  16'd4096,  15'sd16383,  1'b1, 16'd0,    15'd0},
    '{16'd4096,  16'd0,     15'sd0,      1'b0, 16'd0,    15'd0},
    '{16'd4096,  16'd0,     15'sd6434,   1'b0, 16'd0,    15'd0},
    '{16'd8192,  16'd4096,  15'sd12868,  1'b0, 16'd0,    15'd0},
    '{16'd8192,  16'd4096,  -15'sd12868, 1'b0, 16'd0,    15'd0},
    '{16'd8192,  16'd8192,  -15'sd16384, 1'b0, 16'd0,    15'd0},
    '{16'd4505,  16'd4096,  15'sd12868,  1'b0, 16'd0,    15'd0},
    '{16'd4506,  16'd4096,  15'sd12868,  1'b0, 16'd0,    15'd0},
    '{16'd0,     16'd4096,  15'sd819,    1'b0, 16'd0,    15'd0},
    '{16'd0,     16'd4096,  15'sd820,    1'b0, 16'd0,    15'd0},
    '{16'd65535, 16'd65535, 15'sd0,      1'b0, 16'd0,    15'd0},
    '{16'd65535, 16'd0,     15'sd0,      1'b0, 16'd0,    15'd0},
    '{16'd0,     16'd65535, -15'sd1,     1'b0, 16'd0,    15'd0},
    '{16'd0,     16'd0,     15'sd3217,   1'b0, 16'd0,    15'd0},
    '{16'd4096,  16'd65535, -15'sd6434,  1'b0, 16'd0,    15'd0},
    '{16'hAAAA,  16'h5555,  15'h2AAA,    1'b0, 16'd0,    15'd0},
    '{16'h5555,  16'hAAAA,  15'h5555,    1'b0, 16'd0,    15'd0}
  };

  logic [15:0] phase_cfg[7][4] = '{
    '{16'd0,     16'd0,     16'd4096,  16'd4096},
    '{16'd49152, 16'd49152, 16'd65535, 16'd65535},
    '{16'd65535, 16'd49153, 16'd0,     16'd65535},
    '{16'd24576, 16'd8192,  16'd8192,  16'd0},
    '{16'd49152, 16'd0,     16'd1024,  16'd20000},
    '{16'd12345, 16'd40000, 16'd2048,  16'd32768},
    '{16'd4096,  16'd4096,  16'd4096,  16'd4096}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) send_pose(directed_rows[i]);
    settle();
    for (int p = 0; p < 7; p++) begin
      for (int k = 0; k < 4; k++) write_reg(2'(k), phase_cfg[p][k]);
      for (int n = 0; n < 260; n++) send_pose(random_pose());
      settle();
    end
    if (errors == 0) begin
      $display("go_to_goal_heading_controller_top: match");
    end else begin
      $display("go_to_goal_heading_controller_top: mismatch");
    end
    $finish;
  end

endmodule
